// ===== src/qte_pkg.sv =====
package qte_pkg;

   // input and matrix widths
   localparam int QW    = 16;          // Q2.14 component
   localparam int PW    = 2 * QW;      // 16x16 product
   localparam int N2W   = PW + 1;      // squared norm, up to 2^32
   localparam int MW    = PW + 2;      // signed matrix entry, |m| <= 2^32
   localparam int NUMW  = 64;          // mag * 2^30 + n2 / 2
   localparam int Q30W  = 31;          // unsigned Q30 value, up to 2^30
   localparam int SC_LAT = 2 * Q30W + 2;  // divider + square + radicand + root

   // CORDIC
   localparam int MAX_STEPS = 24;
   localparam int PRE_SHIFT = 16;
   localparam int CW        = 54;      // x/y datapath incl. prescale and gain
   localparam int AW        = 27;      // angle accumulator, degrees Q16
   localparam logic signed [AW-1:0] DEG180 = 27'sd11796480;

   // atan(2^-i) in degrees Q16
   function automatic logic signed [AW-1:0] atan_deg(input int unsigned i);
      logic signed [AW-1:0] r;
      case (i)
         0:  r = 27'sd2949120;
         1:  r = 27'sd1740967;
         2:  r = 27'sd919879;
         3:  r = 27'sd466945;
         4:  r = 27'sd234379;
         5:  r = 27'sd117304;
         6:  r = 27'sd58666;
         7:  r = 27'sd29335;
         8:  r = 27'sd14668;
         9:  r = 27'sd7334;
         10: r = 27'sd3667;
         11: r = 27'sd1833;
         12: r = 27'sd917;
         13: r = 27'sd458;
         14: r = 27'sd229;
         15: r = 27'sd115;
         16: r = 27'sd57;
         17: r = 27'sd29;
         18: r = 27'sd14;
         19: r = 27'sd7;
         20: r = 27'sd4;
         21: r = 27'sd2;
         22: r = 27'sd1;
         default: r = 27'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/qte_sincos.sv =====
// sin = floor(num / den), num carrying the rounding term, one quotient bit per stage, then
// cos = floor(sqrt(2^60 - sin^2)) one root bit per stage.
module qte_sincos (
   input  logic                             clock,
   input  logic                             en,
   input  logic [qte_pkg::NUMW-1:0]         num,
   input  logic [qte_pkg::N2W-1:0]          den,
   output logic [qte_pkg::Q30W-1:0]         sin_q30,
   output logic [qte_pkg::Q30W-1:0]         cos_q30
);

   localparam int QB  = qte_pkg::Q30W;
   localparam int DW  = qte_pkg::N2W;
   localparam int RW  = DW + 1;
   localparam int RADW = 2 * QB;
   localparam int SRW = QB + 2;

   // divider stages
   logic [RW-1:0] drem_ff [QB];
   logic [QB-1:0] dlow_ff [QB];
   logic [QB-1:0] dq_ff   [QB];
   logic [DW-1:0] dden_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [RW-1:0] rem_prev;
      logic [QB-1:0] low_prev;
      logic [QB-1:0] q_prev;
      logic [DW-1:0] den_prev;
      logic [RW:0]   trial;
      logic [RW-1:0] rem_in;
      logic [QB-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_prev = {1'b0, num[qte_pkg::NUMW-1:QB]};
         assign low_prev = num[QB-1:0];
         assign q_prev   = '0;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = drem_ff[k-1];
         assign low_prev = dlow_ff[k-1];
         assign q_prev   = dq_ff[k-1];
         assign den_prev = dden_ff[k-1];
      end

      always_comb begin
         trial = {rem_prev, low_prev[QB-1]};
         if (trial >= {2'b00, den_prev}) begin
            rem_in = RW'(trial - {2'b00, den_prev});
            q_in   = {q_prev[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[RW-1:0];
            q_in   = {q_prev[QB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[k] <= rem_in;
            dlow_ff[k] <= {low_prev[QB-2:0], 1'b0};
            dq_ff[k]   <= q_in;
            dden_ff[k] <= den_prev;
         end
      end
   end

   // square and radicand
   logic [QB-1:0]   s1_ff;
   logic [RADW-1:0] sq_ff;
   logic [QB-1:0]   s2_ff;
   logic [RADW-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= dq_ff[QB-1];
         sq_ff  <= RADW'(dq_ff[QB-1]) * RADW'(dq_ff[QB-1]);
         s2_ff  <= s1_ff;
         rad_ff <= (RADW'(1) << 60) - sq_ff;
      end
   end

   // root stages, two radicand bits per stage
   logic [SRW-1:0]  rrem_ff  [QB];
   logic [QB-1:0]   root_ff  [QB];
   logic [RADW-1:0] rrad_ff  [QB];
   logic [QB-1:0]   rs_ff    [QB];

   for (genvar j = 0; j < QB; j++) begin : g_root
      logic [SRW-1:0]  rem_prev;
      logic [QB-1:0]   root_prev;
      logic [RADW-1:0] rad_prev;
      logic [QB-1:0]   s_prev;
      logic [SRW+1:0]  t;
      logic [SRW+1:0]  trial;
      logic [SRW-1:0]  rem_in;
      logic [QB-1:0]   root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_ff;
         assign s_prev    = s2_ff;
      end else begin : g_next
         assign rem_prev  = rrem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign rad_prev  = rrad_ff[j-1];
         assign s_prev    = rs_ff[j-1];
      end

      always_comb begin
         t     = {rem_prev, rad_prev[RADW-1:RADW-2]};
         trial = (SRW+2)'({root_prev, 2'b01});
         if (t >= trial) begin
            rem_in  = SRW'(t - trial);
            root_in = {root_prev[QB-2:0], 1'b1};
         end else begin
            rem_in  = t[SRW-1:0];
            root_in = {root_prev[QB-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rrem_ff[j] <= rem_in;
            root_ff[j] <= root_in;
            rrad_ff[j] <= {rad_prev[RADW-3:0], 2'b00};
            rs_ff[j]   <= s_prev;
         end
      end
   end

   assign sin_q30 = rs_ff[QB-1];
   assign cos_q30 = root_ff[QB-1];

endmodule

// ===== src/qte_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per stage; angle in degrees Q16.
module qte_cordic #(
   parameter int STEPS = 16
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [qte_pkg::MW-1:0]     vec_y,
   input  logic signed [qte_pkg::MW-1:0]     vec_x,
   output logic signed [qte_pkg::AW-1:0]     angle
);

   localparam int NS = (STEPS > qte_pkg::MAX_STEPS) ? qte_pkg::MAX_STEPS : STEPS;
   localparam int CW = qte_pkg::CW;
   localparam int AW = qte_pkg::AW;

   logic signed [CW-1:0] cx_ff [NS+1];
   logic signed [CW-1:0] cy_ff [NS+1];
   logic signed [AW-1:0] cz_ff [NS+1];
   logic                 zero_ff [NS+1];

   // quadrant fold and prescale
   logic signed [CW-1:0] xe, ye, x0, y0;
   logic signed [AW-1:0] z0;
   logic                 zero0;

   always_comb begin
      xe    = CW'(vec_x);
      ye    = CW'(vec_y);
      zero0 = (vec_x == '0) && (vec_y == '0);
      z0    = '0;
      if (vec_x[qte_pkg::MW-1]) begin
         z0 = vec_y[qte_pkg::MW-1] ? -qte_pkg::DEG180 : qte_pkg::DEG180;
         xe = -xe;
         ye = -ye;
      end
      x0 = xe <<< qte_pkg::PRE_SHIFT;
      y0 = ye <<< qte_pkg::PRE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff[0]   <= x0;
         cy_ff[0]   <= y0;
         cz_ff[0]   <= z0;
         zero_ff[0] <= zero0;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_step
      logic signed [CW-1:0] dx, dy, nx, ny;
      logic signed [AW-1:0] nz;

      always_comb begin
         dx = cy_ff[k] >>> k;
         dy = cx_ff[k] >>> k;
         if (!cy_ff[k][CW-1]) begin
            nx = cx_ff[k] + dx;
            ny = cy_ff[k] - dy;
            nz = cz_ff[k] + qte_pkg::atan_deg(k);
         end else begin
            nx = cx_ff[k] - dx;
            ny = cy_ff[k] + dy;
            nz = cz_ff[k] - qte_pkg::atan_deg(k);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[k+1]   <= nx;
            cy_ff[k+1]   <= ny;
            cz_ff[k+1]   <= nz;
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   // atan2(0, 0) is defined as zero
   assign angle = zero_ff[NS] ? '0 : cz_ff[NS];

endmodule

// ===== src/euler_xyz_from_quat.sv =====
// Channel  Dir  Handshake               Beat payload
// req      in   req_valid / req_stall   req_quat_w, req_quat_x, req_quat_y, req_quat_z
// rsp      out  rsp_valid / rsp_stall   rsp_angle_x/y/z, rsp_gimbal, rsp_degenerate
//
// One beat per cycle sustained while rsp_stall does not hold the output beat; latency is
// set by the 31-stage divider and 31-stage square root in qte_sincos and the
// CORDIC stage chain.
// Synchronous active-high reset clears only the valid bits of the pipeline.
// A held rsp beat freezes every stage together; req_stall is raised for that cycle.
module euler_xyz_from_quat #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_angle_x,
   output logic signed [14:0] rsp_angle_y,
   output logic signed [15:0] rsp_angle_z,
   output logic               rsp_gimbal,
   output logic               rsp_degenerate
);

   localparam int NS = (CORDIC_STEPS > qte_pkg::MAX_STEPS) ? qte_pkg::MAX_STEPS
                                                           : CORDIC_STEPS;
   localparam int PW  = qte_pkg::PW;
   localparam int MW  = qte_pkg::MW;
   localparam int N2W = qte_pkg::N2W;
   localparam int AW  = qte_pkg::AW;
   localparam int SC_LAT = qte_pkg::SC_LAT;
   localparam int GW  = N2W + 14;              // n2 * 9999, mag * 10000
   localparam int NV  = 3 + SC_LAT + NS + 2;   // total stage count
   localparam logic signed [15:0] LIM_XZ = 16'sd23040;
   localparam logic signed [15:0] LIM_Y  = 16'sd11520;

   typedef struct packed {
      logic signed [MW-1:0] ox_y;
      logic signed [MW-1:0] ox_x;
      logic signed [MW-1:0] oz_y;
      logic signed [MW-1:0] oz_x;
      logic                 neg;
      logic                 gim;
      logic                 zero;
   } dly_type;

   typedef struct packed {
      logic gim;
      logic zero;
   } flg_type;

   // Q16 degrees to Q8.7 with round-half-up and clamp
   function automatic logic signed [15:0] to_q7(input logic signed [AW-1:0] a,
                                                input logic signed [15:0] lim);
      logic signed [AW:0] t;
      logic signed [AW:0] l;
      t = (AW+1)'(a) + signed'((AW+1)'(256));
      t = t >>> 9;
      l = (AW+1)'(lim);
      if (t > l) t = l;
      if (t < -l) t = -l;
      return 16'(t);
   endfunction

   logic en;
   logic vld_ff [NV];

   // whole pipeline moves unless the output beat is held
   assign en        = !(vld_ff[NV-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NV; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NV; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: products
   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PW-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= req_quat_w * req_quat_w;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         wz_ff <= req_quat_w * req_quat_z;
         xz_ff <= req_quat_x * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         yz_ff <= req_quat_y * req_quat_z;
         wx_ff <= req_quat_w * req_quat_x;
      end
   end

   // stage 2: norm and matrix entries, all scaled by n2
   logic signed [MW-1:0] nsum;
   logic [N2W-1:0]       n2_2_ff;
   logic signed [MW-1:0] m00_2_ff, m01_2_ff, m02_2_ff, m11_2_ff;
   logic signed [MW-1:0] m12_2_ff, m21_2_ff, m22_2_ff;

   assign nsum = MW'(ww_ff) + MW'(xx_ff) + MW'(yy_ff) + MW'(zz_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         n2_2_ff  <= N2W'(nsum);
         m00_2_ff <= nsum - ((MW'(yy_ff) + MW'(zz_ff)) <<< 1);
         m01_2_ff <= (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
         m02_2_ff <= (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
         m11_2_ff <= nsum - ((MW'(xx_ff) + MW'(zz_ff)) <<< 1);
         m12_2_ff <= (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
         m21_2_ff <= (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
         m22_2_ff <= nsum - ((MW'(xx_ff) + MW'(yy_ff)) <<< 1);
      end
   end

   // stage 3: |m02|, dividend with rounding term, gimbal products
   logic [N2W-1:0]              mag;
   logic [N2W-1:0]              n2_3_ff;
   logic [qte_pkg::NUMW-1:0]    num_3_ff;
   logic [GW-1:0]               gl_3_ff, gr_3_ff;
   logic                        neg_3_ff, zero_3_ff;
   logic signed [MW-1:0]        m00_3_ff, m01_3_ff, m11_3_ff, m12_3_ff;
   logic signed [MW-1:0]        m21_3_ff, m22_3_ff;

   assign mag = m02_2_ff[MW-1] ? N2W'(-m02_2_ff) : N2W'(m02_2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         n2_3_ff   <= n2_2_ff;
         num_3_ff  <= qte_pkg::NUMW'({mag, 30'b0}) + qte_pkg::NUMW'(n2_2_ff >> 1);
         gl_3_ff   <= GW'(mag) * GW'(10000);
         gr_3_ff   <= GW'(n2_2_ff) * GW'(9999);
         neg_3_ff  <= m02_2_ff[MW-1];
         zero_3_ff <= (n2_2_ff == '0);
         m00_3_ff  <= m00_2_ff;
         m01_3_ff  <= m01_2_ff;
         m11_3_ff  <= m11_2_ff;
         m12_3_ff  <= m12_2_ff;
         m21_3_ff  <= m21_2_ff;
         m22_3_ff  <= m22_2_ff;
      end
   end

   // sin/cos of Y from the normalized m02
   logic [qte_pkg::Q30W-1:0] sin_q30, cos_q30;

   qte_sincos u_sincos (
      .clock   (clock),
      .en      (en),
      .num     (num_3_ff),
      .den     (n2_3_ff),
      .sin_q30 (sin_q30),
      .cos_q30 (cos_q30)
   );

   // gimbal decision and X/Z operand pick, then delayed to meet sin/cos
   dly_type dly_in;
   dly_type dly_ff [SC_LAT];

   always_comb begin
      dly_in.gim  = (gl_3_ff >= gr_3_ff);
      dly_in.ox_y = dly_in.gim ? m21_3_ff : -m12_3_ff;
      dly_in.ox_x = dly_in.gim ? m11_3_ff : m22_3_ff;
      dly_in.oz_y = -m01_3_ff;
      dly_in.oz_x = m00_3_ff;
      dly_in.neg  = neg_3_ff;
      dly_in.zero = zero_3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= dly_in;
         for (int i = 1; i < SC_LAT; i++) dly_ff[i] <= dly_ff[i-1];
      end
   end

   // three CORDIC lanes side by side
   logic signed [MW-1:0] s_ext, y_vy, y_vx;
   logic signed [AW-1:0] ang_x, ang_y, ang_z;

   assign s_ext = signed'(MW'(sin_q30));
   assign y_vy  = dly_ff[SC_LAT-1].neg ? -s_ext : s_ext;
   assign y_vx  = signed'(MW'(cos_q30));

   qte_cordic #(.STEPS(NS)) u_cordic_x (
      .clock (clock),
      .en    (en),
      .vec_y (dly_ff[SC_LAT-1].ox_y),
      .vec_x (dly_ff[SC_LAT-1].ox_x),
      .angle (ang_x)
   );

   qte_cordic #(.STEPS(NS)) u_cordic_y (
      .clock (clock),
      .en    (en),
      .vec_y (y_vy),
      .vec_x (y_vx),
      .angle (ang_y)
   );

   qte_cordic #(.STEPS(NS)) u_cordic_z (
      .clock (clock),
      .en    (en),
      .vec_y (dly_ff[SC_LAT-1].oz_y),
      .vec_x (dly_ff[SC_LAT-1].oz_x),
      .angle (ang_z)
   );

   // flags ride alongside the CORDIC stages
   flg_type flg_ff [NS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         flg_ff[0].gim  <= dly_ff[SC_LAT-1].gim;
         flg_ff[0].zero <= dly_ff[SC_LAT-1].zero;
         for (int i = 1; i <= NS; i++) flg_ff[i] <= flg_ff[i-1];
      end
   end

   // output register: Q8.7 conversion and special cases
   logic signed [15:0] ax_ff, az_ff;
   logic signed [14:0] ay_ff;
   logic               gim_ff, deg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (flg_ff[NS].zero) begin
            ax_ff  <= '0;
            ay_ff  <= '0;
            az_ff  <= '0;
            gim_ff <= 1'b0;
            deg_ff <= 1'b1;
         end else begin
            ax_ff  <= to_q7(ang_x, LIM_XZ);
            ay_ff  <= 15'(to_q7(ang_y, LIM_Y));
            az_ff  <= flg_ff[NS].gim ? '0 : to_q7(ang_z, LIM_XZ);
            gim_ff <= flg_ff[NS].gim;
            deg_ff <= 1'b0;
         end
      end
   end

   assign rsp_angle_x    = ax_ff;
   assign rsp_angle_y    = ay_ff;
   assign rsp_angle_z    = az_ff;
   assign rsp_gimbal     = gim_ff;
   assign rsp_degenerate = deg_ff;

   // a zero quaternion reports nothing but the degenerate flag
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_angle_x == '0 && rsp_angle_y == '0 &&
                                      rsp_angle_z == '0 && !rsp_gimbal)
      else $error("degenerate beat carries nonzero angles");

   // gimbal lock pins Z to zero
   a_gimbal_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal |-> rsp_angle_z == '0)
      else $error("gimbal beat with nonzero Z angle");

   // Y stays within +-90 degrees
   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_y >= -15'sd11520 && rsp_angle_y <= 15'sd11520)
      else $error("Y angle out of range");

   // stall is raised only while an output beat is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held output beat");

endmodule
